[hw/rtl/tabn_pkg.sv]
// Shared types and constants for the three-axis biquad notch filter.
// No dependencies; imported by the lane and top-level modules.
package tabn_pkg;

  localparam int NUM_AXES  = 3;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = COEF_W - 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // accumulator follows the reference width, capped at 64 bits (wraps there)
  localparam int ACC_W     = (COEF_W + SAMPLE_W + 3 > 64) ? 64 : COEF_W + SAMPLE_W + 3;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // half an LSB of the output, for round to nearest (ties up)
  localparam acc_t ACC_RND = {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam acc_t ACC_SAT_HI = {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam acc_t ACC_SAT_LO = {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  // pipeline strobes shared by all lanes
  typedef struct packed {
    logic load_a;   // new sample enters the product stage
    logic adv_b;    // product stage retires into the output/feedback registers
  } lane_ctrl_t;

endpackage

[hw/rtl/tabn_lane.sv]
// One axis of the biquad: feedforward product stage, then the feedback
// sum with rounding and saturation. Depends on tabn_pkg.
module tabn_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tabn_pkg::lane_ctrl_t ctrl,
  input  tabn_pkg::coef_set_t  coefs,
  input  tabn_pkg::sample_t    x,
  output tabn_pkg::sample_t    y
);
  import tabn_pkg::*;

  sample_t x1_r, x2_r, y1_r, y2_r;
  prod_t   pb0_r, pb1_r, pb2_r;

  prod_t   pb0_nxt, pb1_nxt, pb2_nxt;
  prod_t   fb1, fb2;
  acc_t    acc;
  acc_t    acc_q;
  sample_t y_nxt;

  // feedforward products, registered before the sum
  assign pb0_nxt = PROD_W'(coefs.b0) * PROD_W'(x);
  assign pb1_nxt = PROD_W'(coefs.b1) * PROD_W'(x1_r);
  assign pb2_nxt = PROD_W'(coefs.b2) * PROD_W'(x2_r);

  // feedback products: the recursion closes through the y1_r/y2_r history
  assign fb1 = PROD_W'(coefs.a1) * PROD_W'(y1_r);
  assign fb2 = PROD_W'(coefs.a2) * PROD_W'(y2_r);

  always_comb begin
    acc   = ACC_W'(pb0_r) + ACC_W'(pb1_r) + ACC_W'(pb2_r)
          - ACC_W'(fb1) - ACC_W'(fb2) + ACC_RND;
    acc_q = acc >>> COEF_FRAC;
    if (acc_q > ACC_SAT_HI) begin
      y_nxt = ACC_SAT_HI[SAMPLE_W-1:0];
    end else if (acc_q < ACC_SAT_LO) begin
      y_nxt = ACC_SAT_LO[SAMPLE_W-1:0];
    end else begin
      y_nxt = acc_q[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else begin
      if (ctrl.load_a) begin
        x1_r <= x;
        x2_r <= x1_r;
      end
      if (ctrl.adv_b) begin
        y1_r <= y_nxt;
        y2_r <= y1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_a) begin
      pb0_r <= pb0_nxt;
      pb1_r <= pb1_nxt;
      pb2_r <= pb2_nxt;
    end
  end

  // newest output doubles as the result register
  assign y = y1_r;

endmodule

[hw/rtl/three_axis_biquad_notch_filter_unit.sv]
// Top level of the three-axis biquad notch filter: coefficient registers,
// pipeline control and one tabn_lane per axis. Depends on tabn_pkg, tabn_lane.
//
// Usage:
//  - cfg channel: one transfer writes coefficient cfg_index (0 b0, 1 b1,
//    2 b2, 3 a1, 4 a2) with cfg_wdata, signed Q2.15. Other indexes are
//    dropped. cfg_ready is always high. Write only while the filter is idle.
//  - in channel: one transfer carries one sample for each of three axes.
//  - out channel: one transfer per input transfer, same order, each axis
//    filtered independently with shared coefficients, rounded to nearest
//    and saturated to 16 bits.
//  - Path: the input transfer loads the product stage, which then retires
//    into the result registers (feedback sum), where out_valid rises.
//    Throughput: one item per cycle while the receiver keeps up, as the
//    a1/a2 feedback multiply-add in each lane is combinational.
//  - Reset (rst_n low at a clock edge) clears coefficients and all filter
//    history to zero, and empties the pipeline.
//  - Receiver stall: the result holds on out_*; one more item may sit in
//    the product stage, after which in_ready drops until out_ready returns.
module three_axis_biquad_notch_filter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tabn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tabn_pkg::COEF_W-1:0]      cfg_wdata,
  // samples in
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [tabn_pkg::SAMPLE_W-1:0] in_sample_axis0,
  input  logic signed [tabn_pkg::SAMPLE_W-1:0] in_sample_axis1,
  input  logic signed [tabn_pkg::SAMPLE_W-1:0] in_sample_axis2,
  // results out
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tabn_pkg::SAMPLE_W-1:0] out_filtered_axis0,
  output logic signed [tabn_pkg::SAMPLE_W-1:0] out_filtered_axis1,
  output logic signed [tabn_pkg::SAMPLE_W-1:0] out_filtered_axis2
);
  import tabn_pkg::*;

  coef_set_t  coef_r;
  logic       sa_v_r, sa_v_nxt;    // product stage holds an item
  logic       out_v_r, out_v_nxt;  // result registers hold an item
  lane_ctrl_t ctrl;
  sample_t    lane_x [NUM_AXES];
  sample_t    lane_y [NUM_AXES];

  // Coefficient writes; always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_B0:  coef_r.b0 <= cfg_wdata;
        REG_B1:  coef_r.b1 <= cfg_wdata;
        REG_B2:  coef_r.b2 <= cfg_wdata;
        REG_A1:  coef_r.a1 <= cfg_wdata;
        REG_A2:  coef_r.a2 <= cfg_wdata;
        default: ;  // unused index: write is dropped
      endcase
    end
  end

  // Two-stage pipeline control. The feedback stage retires whenever the
  // result slot is free or being drained, so a new sample can enter every
  // cycle as long as the receiver keeps up.
  always_comb begin
    ctrl.adv_b  = sa_v_r && (!out_v_r || out_ready);
    in_ready    = !sa_v_r || ctrl.adv_b;
    ctrl.load_a = in_valid && in_ready;

    sa_v_nxt = sa_v_r;
    if (ctrl.load_a) begin
      sa_v_nxt = 1'b1;
    end else if (ctrl.adv_b) begin
      sa_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (ctrl.adv_b) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      sa_v_r  <= sa_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign lane_x[0] = in_sample_axis0;
  assign lane_x[1] = in_sample_axis1;
  assign lane_x[2] = in_sample_axis2;

  // One filter lane per axis, all stepping together.
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    tabn_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .coefs (coef_r),
      .x     (lane_x[g]),
      .y     (lane_y[g])
    );
  end

  // Merge: the lanes' newest outputs form one result item. They only
  // change on adv_b, so they hold steady while the receiver stalls.
  assign out_valid          = out_v_r;
  assign out_filtered_axis0 = lane_y[0];
  assign out_filtered_axis1 = lane_y[1];
  assign out_filtered_axis2 = lane_y[2];

endmodule

[hw/rtl/tabn_chk.sv]
// Port-level checker for the three-axis biquad notch filter, bound to the
// top level. Depends on tabn_pkg for widths.
module tabn_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [tabn_pkg::SAMPLE_W-1:0]      out_filtered_axis0,
  input logic [tabn_pkg::SAMPLE_W-1:0]      out_filtered_axis1,
  input logic [tabn_pkg::SAMPLE_W-1:0]      out_filtered_axis2
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_axis0)
      && $stable(out_filtered_axis1) && $stable(out_filtered_axis2))
    else $error("result changed while stalled");

  // out_valid rises only for an input transfer that has passed the product stage
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input");

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // with the output empty, an accepted sample passes the product stage and raises out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) ##1 !out_valid |=> out_valid)
    else $error("result missing after two cycles");

endmodule

bind three_axis_biquad_notch_filter_unit tabn_chk u_tabn_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_axis0 (out_filtered_axis0),
  .out_filtered_axis1 (out_filtered_axis1),
  .out_filtered_axis2 (out_filtered_axis2)
);

[sim/three_axis_biquad_notch_filter_unit_tb.sv]
// Self-checking bench for three_axis_biquad_notch_filter_unit: table-driven
// directed rows, then random coefficient phases checked by a biquad predictor.
// Depends on tabn_pkg and the filter RTL only.
`timescale 1ns / 100ps

module three_axis_biquad_notch_filter_unit_tb;
  import tabn_pkg::*;

  // three samples, axis 0 in the low slot
  typedef logic [NUM_AXES-1:0][SAMPLE_W-1:0] axes_t;

  typedef enum logic [1:0] {
    ROW_CFG,    // coefficient register write
    ROW_ITEM,   // sample transfer, result from the predictor
    ROW_FIXED   // sample transfer, result typed into the table
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    coef_t                  data;
    axes_t                  samp;
    axes_t                  want;
  } row_t;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 7;
  localparam int DRAIN_CYCLES    = 6;       // pipeline latency plus margin
  localparam int CYCLE_LIMIT     = 200000;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int IDLE_PCT        = 32;

  // indexes past a2 are decoded as nothing
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  // Q2.15 landmarks
  localparam coef_t COEF_MAX  = 18'sd131071;   // just under +4.0
  localparam coef_t COEF_MIN  = -18'sd131072;  // -4.0
  localparam coef_t Q_ONE     = 18'sd32768;    // 1.0
  localparam coef_t Q_HALF    = 18'sd16384;    // 0.5
  // notch at fs/6, pole radius 0.9: a1 = -2*0.9*cos, a2 = 0.81
  localparam coef_t NOTCH_A1  = -18'sd29491;
  localparam coef_t NOTCH_A2  = 18'sd26542;

  localparam sample_t SAMP_MAX = 16'sh7fff;
  localparam sample_t SAMP_MIN = -16'sh8000;

  localparam longint ROUND_HALF = longint'(1) << (COEF_FRAC - 1);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COEF_W-1:0]     cfg_wdata = '0;

  logic    in_valid        = 1'b0;
  logic    in_ready;
  sample_t in_sample_axis0 = '0;
  sample_t in_sample_axis1 = '0;
  sample_t in_sample_axis2 = '0;

  logic    out_valid;
  logic    out_ready       = 1'b0;
  sample_t out_filtered_axis0;
  sample_t out_filtered_axis1;
  sample_t out_filtered_axis2;

  three_axis_biquad_notch_filter_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_axis0    (in_sample_axis0),
    .in_sample_axis1    (in_sample_axis1),
    .in_sample_axis2    (in_sample_axis2),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_axis0 (out_filtered_axis0),
    .out_filtered_axis1 (out_filtered_axis1),
    .out_filtered_axis2 (out_filtered_axis2)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state: shared coefficients plus per-axis DF-I history.
  coef_set_t coefs = '0;
  sample_t   x_d1 [NUM_AXES] = '{default: '0};
  sample_t   x_d2 [NUM_AXES] = '{default: '0};
  sample_t   y_d1 [NUM_AXES] = '{default: '0};
  sample_t   y_d2 [NUM_AXES] = '{default: '0};

  axes_t pending_outputs [$];   // filtered triples still owed by the block
  row_t  row_q [$];             // directed stimulus table
  bit    quiet       = 1'b0;    // no idling on either side while set
  int    failures    = 0;
  int    cycle_count = 0;
  axes_t want_y, got_y;

  // One biquad step per axis. Full-precision sum, +half LSB, arithmetic
  // shift to drop the Q15 fraction, then clamp; the clamped value feeds back.
  function automatic axes_t biquad_predict(input axes_t x);
    axes_t   y;
    sample_t xi;
    sample_t yi;
    longint  acc;
    for (int i = 0; i < NUM_AXES; i++) begin
      xi  = x[i];
      acc = longint'(coefs.b0) * xi
          + longint'(coefs.b1) * x_d1[i]
          + longint'(coefs.b2) * x_d2[i]
          - longint'(coefs.a1) * y_d1[i]
          - longint'(coefs.a2) * y_d2[i];
      acc = (acc + ROUND_HALF) >>> COEF_FRAC;
      if (acc > longint'(SAMP_MAX)) yi = SAMP_MAX;
      else if (acc < longint'(SAMP_MIN)) yi = SAMP_MIN;
      else yi = sample_t'(acc);
      x_d2[i] = x_d1[i];
      x_d1[i] = xi;
      y_d2[i] = y_d1[i];
      y_d1[i] = yi;
      y[i]    = yi;
    end
    return y;
  endfunction

  function automatic axes_t mk3(input sample_t a0, input sample_t a1, input sample_t a2);
    return {a2, a1, a0};
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input coef_t d);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = d;
    return r;
  endfunction

  function automatic row_t item_row(input axes_t s);
    row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.samp = s;
    return r;
  endfunction

  function automatic row_t fixed_row(input axes_t s, input axes_t w);
    row_t r;
    r      = '0;
    r.kind = ROW_FIXED;
    r.samp = s;
    r.want = w;
    return r;
  endfunction

  // Mix of full-range noise, rails and small signals so that every bit
  // toggles and the recursion sees both quiet and clipping inputs.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 3))
          0:       return SAMP_MAX;
          1:       return SAMP_MIN;
          2:       return '0;
          default: return -16'sd1;
        endcase
      end
      2, 3:    return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic coef_t rail_coef();
    case ($urandom_range(0, 3))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      default: return Q_ONE;
    endcase
  endfunction

  // Phase coefficient sets: notch, full random, rails, mild random.
  function automatic coef_set_t phase_coefs(input int ph);
    coef_set_t c;
    case (ph % 4)
      0: begin
        c.b0 = Q_ONE;  c.b1 = -Q_ONE;  c.b2 = Q_ONE;
        c.a1 = NOTCH_A1;  c.a2 = NOTCH_A2;
      end
      1: begin
        c.b0 = coef_t'($urandom());  c.b1 = coef_t'($urandom());
        c.b2 = coef_t'($urandom());  c.a1 = coef_t'($urandom());
        c.a2 = coef_t'($urandom());
      end
      2: begin
        c.b0 = rail_coef();  c.b1 = rail_coef();  c.b2 = rail_coef();
        c.a1 = rail_coef();  c.a2 = rail_coef();
      end
      default: begin
        c.b0 = coef_t'(int'($urandom_range(0, 65536)) - 32768);
        c.b1 = coef_t'(int'($urandom_range(0, 65536)) - 32768);
        c.b2 = coef_t'(int'($urandom_range(0, 65536)) - 32768);
        c.a1 = coef_t'(int'($urandom_range(0, 32768)) - 16384);
        c.a2 = coef_t'(int'($urandom_range(0, 16384)) - 8192);
      end
    endcase
    return c;
  endfunction

  // Drop in_valid, let the pipe empty, then allow for the latency.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One cfg transfer; cfg_valid is left high so back-to-back writes do not
  // toggle it, the caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coef_t d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_B0:  coefs.b0 = d;
      REG_B1:  coefs.b1 = d;
      REG_B2:  coefs.b2 = d;
      REG_A1:  coefs.a1 = d;
      REG_A2:  coefs.a2 = d;
      default: ;  // unused index, block drops it
    endcase
  endtask

  // One input transfer with a random pre-gap. The predictor always runs so
  // the history stays in step; a typed-in result overrides its answer.
  task automatic send_item(input axes_t s, input bit use_want, input axes_t w);
    axes_t y;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_axis0 <= s[0];
    in_sample_axis1 <= s[1];
    in_sample_axis2 <= s[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    y = biquad_predict(s);
    pending_outputs.push_back(use_want ? w : y);
  endtask

  // Receiver: random back-pressure, and the scoreboard compare on each
  // accepted result transfer.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    if (rst_n && out_valid && out_ready) begin
      got_y = {out_filtered_axis2, out_filtered_axis1, out_filtered_axis0};
      if (pending_outputs.size() == 0) begin
        $error("unexpected result transfer: %0d %0d %0d", $signed(got_y[0]),
               $signed(got_y[1]), $signed(got_y[2]));
        failures++;
      end else begin
        want_y = pending_outputs.pop_front();
        for (int i = 0; i < NUM_AXES; i++) begin
          if (got_y[i] !== want_y[i]) begin
            $error("filtered_axis%0d: expected %0d, actual %0d", i,
                   $signed(want_y[i]), $signed(got_y[i]));
            failures++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** three_axis_biquad_notch_filter_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    coef_set_t cs;

    // Directed table. Coefficients come out of reset at zero, so the first
    // rows must read back zero whatever the samples are.
    row_q.push_back(fixed_row(mk3(SAMP_MAX, SAMP_MIN, 16'sd1), mk3(0, 0, 0)));
    row_q.push_back(fixed_row(mk3(-16'sd1, 16'sd0, 16'sd21845), mk3(0, 0, 0)));
    // unity gain; writes to unused indexes must not disturb it
    row_q.push_back(cfg_row(REG_B0, Q_ONE));
    row_q.push_back(cfg_row(IDX_SPARE_LO, COEF_MIN));
    row_q.push_back(cfg_row(IDX_SPARE_HI, COEF_MAX));
    row_q.push_back(fixed_row(mk3(SAMP_MAX, SAMP_MIN, 16'sd0),
                              mk3(SAMP_MAX, SAMP_MIN, 16'sd0)));
    row_q.push_back(fixed_row(mk3(-16'sd1, 16'sd1, 16'sd21845),
                              mk3(-16'sd1, 16'sd1, 16'sd21845)));
    row_q.push_back(fixed_row(mk3(-16'sd21846, 16'sd12345, -16'sd12345),
                              mk3(-16'sd21846, 16'sd12345, -16'sd12345)));
    // gain of one half: odd inputs land on exact ties, which round upward
    row_q.push_back(cfg_row(REG_B0, Q_HALF));
    row_q.push_back(fixed_row(mk3(16'sd1, -16'sd1, 16'sd3), mk3(16'sd1, 16'sd0, 16'sd2)));
    row_q.push_back(fixed_row(mk3(-16'sd3, SAMP_MAX, SAMP_MIN),
                              mk3(-16'sd1, 16'sd16384, -16'sd16384)));
    // largest and smallest gains drive the output onto the rails
    row_q.push_back(cfg_row(REG_B0, COEF_MAX));
    row_q.push_back(fixed_row(mk3(SAMP_MAX, SAMP_MIN, 16'sd8192),
                              mk3(SAMP_MAX, SAMP_MIN, SAMP_MAX)));
    row_q.push_back(cfg_row(REG_B0, COEF_MIN));
    row_q.push_back(fixed_row(mk3(SAMP_MAX, SAMP_MIN, -16'sd1),
                              mk3(SAMP_MIN, SAMP_MAX, 16'sd4)));
    // every tap at a rail: the feedback path saturates hard
    row_q.push_back(cfg_row(REG_B1, COEF_MAX));
    row_q.push_back(cfg_row(REG_B2, COEF_MIN));
    row_q.push_back(cfg_row(REG_A1, COEF_MIN));
    row_q.push_back(cfg_row(REG_A2, COEF_MAX));
    row_q.push_back(item_row(mk3(SAMP_MAX, SAMP_MIN, 16'sd100)));
    row_q.push_back(item_row(mk3(SAMP_MIN, SAMP_MAX, -16'sd100)));
    row_q.push_back(item_row(mk3(16'sd0, 16'sd0, 16'sd0)));
    row_q.push_back(item_row(mk3(SAMP_MAX, SAMP_MAX, SAMP_MAX)));
    row_q.push_back(item_row(mk3(-16'sd1, 16'sd1, 16'sd0)));
    // textbook notch
    row_q.push_back(cfg_row(REG_B0, Q_ONE));
    row_q.push_back(cfg_row(REG_B1, -Q_ONE));
    row_q.push_back(cfg_row(REG_B2, Q_ONE));
    row_q.push_back(cfg_row(REG_A1, NOTCH_A1));
    row_q.push_back(cfg_row(REG_A2, NOTCH_A2));
    row_q.push_back(item_row(mk3(16'sd10000, -16'sd10000, 16'sd0)));
    row_q.push_back(item_row(mk3(16'sd10000, -16'sd10000, 16'sd0)));
    row_q.push_back(item_row(mk3(-16'sd20000, 16'sd20000, SAMP_MAX)));
    row_q.push_back(item_row(mk3(16'sd10000, -16'sd10000, SAMP_MIN)));
    row_q.push_back(item_row(mk3(16'sd10000, -16'sd10000, SAMP_MAX)));
    row_q.push_back(item_row(mk3(-16'sd20000, 16'sd20000, 16'sd1)));

    // Synchronous reset held across several edges, then released once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table. Config writes only go in once the pipe is empty.
    for (int n = 0; n < row_q.size(); n++) begin
      if (row_q[n].kind == ROW_CFG) begin
        if (n == 0 || row_q[n-1].kind != ROW_CFG) wait_drain();
        write_reg(row_q[n].idx, row_q[n].data);
        if (n + 1 == row_q.size() || row_q[n+1].kind != ROW_CFG) cfg_valid <= 1'b0;
      end else begin
        send_item(row_q[n].samp, row_q[n].kind == ROW_FIXED, row_q[n].want);
      end
    end

    // Random phases, each with a fresh coefficient set written while idle.
    // Filter history carries across phases, as it does in the block.
    // Phase 2 runs with both sides always ready to keep the pipe full.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drain();
      quiet = (ph == 2);
      cs    = phase_coefs(ph);
      write_reg(REG_B0, cs.b0);
      write_reg(REG_B1, cs.b1);
      write_reg(REG_B2, cs.b2);
      write_reg(REG_A1, cs.a1);
      write_reg(REG_A2, cs.a2);
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)),
                  coef_t'($urandom()));
      cfg_valid <= 1'b0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_item(mk3(rand_sample(), rand_sample(), rand_sample()), 1'b0, '0);
    end

    quiet = 1'b0;
    wait_drain();
    if (pending_outputs.size() != 0) begin
      $error("%0d results never arrived", pending_outputs.size());
      failures++;
    end
    if (failures == 0) begin
      $display("** three_axis_biquad_notch_filter_unit: PASSED **");
    end else begin
      $display("** three_axis_biquad_notch_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule
